// ===== hdl/imu_angle_frame_parser_unit_defines.svh =====
`ifndef IMU_ANGLE_FRAME_PARSER_UNIT_DEFINES_SVH
`define IMU_ANGLE_FRAME_PARSER_UNIT_DEFINES_SVH

// concurrent check, sampled on clk, off while rst is high
`define AFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form of the above
`define AFP_ASSERT_IMP(label, ante, cons, msg) \
  `AFP_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== hdl/afp_pkg.sv =====
package afp_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FRAME_TYPE = 2'd1;

  localparam logic [7:0] HEADER_RESET = 8'h55;
  localparam logic [7:0] ANGLE_TYPE_RESET = 8'h53;

  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_TYPE = 4'd1;
  localparam logic [3:0] POS_PAYLOAD_FIRST = 4'd2;
  localparam logic [3:0] POS_PAYLOAD_LAST = 4'd7;
  localparam logic [3:0] POS_CHECKSUM = 4'd10;

  localparam int unsigned PAYLOAD_BYTES = 6;

  // raw * 18000 / 32768 gives centidegrees
  localparam logic signed [15:0] CDEG_SCALE = 16'sd18000;
  localparam logic [15:0] YAW_WRAP = 16'd36000;

  typedef enum logic [1:0] {
    ST_ANGLES   = 2'd0,
    ST_OTHER    = 2'd1,
    ST_CSUM_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic done;
    logic csum_ok;
    logic type_match;
  } frame_evt_t;

  typedef logic [PAYLOAD_BYTES-1:0][7:0] payload_t;

endpackage

// ===== hdl/afp_frame_tracker.sv =====
module afp_frame_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        rx_q,
  input  logic [7:0]        header_byte,
  input  logic [7:0]        angle_frame_type,
  output afp_pkg::frame_evt_t evt,
  output afp_pkg::payload_t payload
);

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [7:0] sum;
  logic [7:0] sum_next;
  logic [7:0] type_byte;
  logic [2:0] slot;

  assign slot = 3'(pos - afp_pkg::POS_PAYLOAD_FIRST);

  assign evt.done = (pos == afp_pkg::POS_CHECKSUM);
  assign evt.csum_ok = (rx_q == sum);
  assign evt.type_match = (type_byte == angle_frame_type);

  always_comb begin
    pos_next = pos;
    sum_next = sum;
    if (pos == afp_pkg::POS_HEADER) begin
      if (rx_q == header_byte) begin
        pos_next = afp_pkg::POS_TYPE;
        sum_next = rx_q;
      end
    end else if (pos < afp_pkg::POS_CHECKSUM) begin
      pos_next = pos + 4'd1;
      sum_next = sum + rx_q;
    end else begin
      pos_next = afp_pkg::POS_HEADER;
      sum_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= afp_pkg::POS_HEADER;
      sum <= 8'd0;
    end else if (go) begin
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (pos == afp_pkg::POS_TYPE) begin
        type_byte <= rx_q;
      end
      if (pos >= afp_pkg::POS_PAYLOAD_FIRST && pos <= afp_pkg::POS_PAYLOAD_LAST) begin
        payload[slot] <= rx_q;
      end
    end
  end

endmodule

// ===== hdl/afp_angle_conv.sv =====
module afp_angle_conv (
  input  logic [7:0]  lo,
  input  logic [7:0]  hi,
  input  logic        wrap_neg,
  output logic [15:0] cdeg
);

  logic signed [15:0] raw;
  logic signed [31:0] prod;
  logic [15:0] scaled;

  assign raw = $signed({hi, lo});
  assign prod = raw * afp_pkg::CDEG_SCALE;
  // floor division by 32768; result fits in 16 bits
  assign scaled = prod[30:15];
  assign cdeg = (wrap_neg && raw[15]) ? 16'(scaled + afp_pkg::YAW_WRAP) : scaled;

endmodule

// ===== hdl/imu_angle_frame_parser_unit.sv =====
// Serial angle-frame parser. One rx_byte beat is taken per clock while in_ready is
// high; each byte passes an input register and the frame tracker, and the checksum
// byte of an 11-byte frame then loads the result register unless a result beat that
// is not yet taken holds it, so the block sustains one byte per cycle while out_ready
// is high. A byte that should be a header but is not is dropped. A completed frame
// gives one result beat: status 0 with fresh angles, 1 for a good frame of another
// type, 2 for a bad checksum; in the last two cases the held angles are shown
// unchanged. Angles are in centidegrees, yaw wrapped to 0..35999. Configuration writes
// are always ready and are meant to be made while no frame is in flight.
module imu_angle_frame_parser_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     frame_status,
  output logic signed [15:0]             roll_cdeg,
  output logic signed [15:0]             pitch_cdeg,
  output logic [15:0]                    yaw_cdeg,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic [7:0] header_byte;
  logic [7:0] angle_frame_type;
  logic [7:0] rx_q;
  logic rx_q_valid;
  logic go;
  afp_pkg::frame_evt_t evt;
  afp_pkg::payload_t payload;
  logic [15:0] roll_conv;
  logic [15:0] pitch_conv;
  logic [15:0] yaw_conv;
  afp_pkg::status_t status;
  afp_pkg::status_t status_next;
  logic [15:0] held_roll;
  logic [15:0] held_pitch;
  logic [15:0] held_yaw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= afp_pkg::HEADER_RESET;
      angle_frame_type <= afp_pkg::ANGLE_TYPE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        afp_pkg::CFG_HEADER_BYTE: header_byte <= cfg_data;
        afp_pkg::CFG_ANGLE_FRAME_TYPE: angle_frame_type <= cfg_data;
        default: ;
      endcase
    end
  end

  assign go = rx_q_valid && (!evt.done || !out_valid || out_ready);
  assign in_ready = !rx_q_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_q_valid <= 1'b0;
    end else if (in_ready) begin
      rx_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rx_q <= rx_byte;
    end
  end

  afp_frame_tracker u_tracker (
    .clk              (clk),
    .rst              (rst),
    .go               (go),
    .rx_q             (rx_q),
    .header_byte      (header_byte),
    .angle_frame_type (angle_frame_type),
    .evt              (evt),
    .payload          (payload)
  );

  afp_angle_conv u_roll (
    .lo (payload[0]), .hi (payload[1]), .wrap_neg (1'b0), .cdeg (roll_conv)
  );

  afp_angle_conv u_pitch (
    .lo (payload[2]), .hi (payload[3]), .wrap_neg (1'b0), .cdeg (pitch_conv)
  );

  afp_angle_conv u_yaw (
    .lo (payload[4]), .hi (payload[5]), .wrap_neg (1'b1), .cdeg (yaw_conv)
  );

  always_comb begin
    if (!evt.csum_ok) begin
      status_next = afp_pkg::ST_CSUM_ERR;
    end else if (evt.type_match) begin
      status_next = afp_pkg::ST_ANGLES;
    end else begin
      status_next = afp_pkg::ST_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_roll <= 16'd0;
      held_pitch <= 16'd0;
      held_yaw <= 16'd0;
    end else begin
      if (go && evt.done) begin
        out_valid <= 1'b1;
        if (status_next == afp_pkg::ST_ANGLES) begin
          held_roll <= roll_conv;
          held_pitch <= pitch_conv;
          held_yaw <= yaw_conv;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && evt.done) begin
      status <= status_next;
    end
  end

  assign frame_status = status;
  assign roll_cdeg = $signed(held_roll);
  assign pitch_cdeg = $signed(held_pitch);
  assign yaw_cdeg = held_yaw;

endmodule

// ===== hdl/afp_checker.sv =====
`include "imu_angle_frame_parser_unit_defines.svh"

module afp_sva_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    frame_status,
  input logic signed [15:0]            roll_cdeg,
  input logic signed [15:0]            pitch_cdeg,
  input logic [15:0]                   yaw_cdeg
);

  `AFP_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 out_valid, "result beat dropped")
  `AFP_ASSERT_IMP(a_status_code, out_valid, frame_status != 2'd3, "bad status code")
  `AFP_ASSERT_IMP(a_roll_range, out_valid, roll_cdeg >= -16'sd18000 && roll_cdeg < 16'sd18000, "roll out of range")
  `AFP_ASSERT_IMP(a_yaw_range, out_valid, yaw_cdeg < 16'd36000, "yaw out of range")
  `AFP_ASSERT_IMP(a_angles_hold, !$past(rst) && !$stable(pitch_cdeg), out_valid && frame_status == afp_pkg::ST_ANGLES, "pitch moved without an angle frame")

endmodule

bind imu_angle_frame_parser_unit afp_sva_checker u_afp_sva_checker (.*);
